// ===== rtl/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Blocked matrix multiply package
// Shared types, codes and constants for the blocked matrix multiplier.
// ----------------------------------------------------------------------------
package bmm_pkg;

    // Default matrix dimension of the stores.
    localparam int MAX_DIM_DEF = 8;
    // Width of row, column and inner indexes in the request and result.
    localparam int IDX_W = 3;
    // Width of the exact column sum before saturation.
    localparam int ACC_W = 67;

    // Function codes of a request.
    typedef enum logic [1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    // Configuration register byte addresses.
    localparam logic [1:0] ADDR_ACTIVE_SIZE = 2'd0;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic signed [31:0] element_value;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_row;
        logic [IDX_W-1:0]   out_col;
        logic signed [63:0] product_value;
        logic               last_element;
    } result_t;

    // Control word that travels along the cell chain with each B element.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_col;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } chain_ctl_t;

    // Finished element offered by one cell.
    typedef struct packed {
        logic    valid;
        result_t data;
    } cell_out_t;

endpackage

// ===== rtl/bmm_cell.sv =====
// ----------------------------------------------------------------------------
// Blocked matrix multiply cell
// Holds one row of A, multiplies it with the B column streaming past and
// accumulates one element of C; hands the B stream on to its neighbor.
// ----------------------------------------------------------------------------
module bmm_cell
    import bmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int INDEX   = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              a_we,
    input  logic [IDX_W-1:0]  a_col,
    input  logic [31:0]       a_data,
    input  logic [IDX_W-1:0]  nlast,
    input  logic [31:0]       b_in,
    input  chain_ctl_t        ctl_in,
    output logic [31:0]       b_out,
    output chain_ctl_t        ctl_out,
    output cell_out_t         res
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic [31:0]        a_row_reg [MAX_DIM];
    logic [31:0]        b_reg;
    chain_ctl_t         ctl_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    chain_ctl_t         ctl2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    chain_ctl_t         ctl3_reg;
    cell_out_t          res_reg;
    cell_out_t          res_next;

    // Row of A, written by load requests for this row.
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_row_reg[a_col[IW-1:0]] <= a_data;
        end
    end

    // Take the control word from the left and delay it; register the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            ctl2_reg <= ctl_reg;
            ctl3_reg <= ctl2_reg;
            res_reg  <= res_next;
        end
    end

    // Product of the matching A element and the passing B element.
    assign prod_next = $signed(a_row_reg[ctl_reg.k[IW-1:0]]) * $signed(b_reg);

    // Accumulate; the first inner step of a column restarts the sum.
    always_comb
    begin
        acc_next = (ctl2_reg.first ? '0 : acc_reg)
                   + {{(ACC_W-64){prod_reg[63]}}, prod_reg};
    end

    // Saturate the finished sum and mark the final element of the run.
    always_comb
    begin
        res_next = '0;
        res_next.valid = ctl3_reg.valid && ctl3_reg.last_k
                         && (IDX_W'(INDEX) <= nlast);
        res_next.data.out_row = IDX_W'(INDEX);
        res_next.data.out_col = ctl3_reg.col;
        res_next.data.last_element = ctl3_reg.last_col && (IDX_W'(INDEX) == nlast);
        if (acc_reg[ACC_W-1:63] == '0 || acc_reg[ACC_W-1:63] == '1)
        begin
            res_next.data.product_value = acc_reg[63:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            res_next.data.product_value = {1'b1, 63'd0};
        end
        else
        begin
            res_next.data.product_value = {1'b0, {63{1'b1}}};
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        b_reg    <= b_in;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign b_out   = b_reg;
    assign ctl_out = ctl_reg;
    assign res     = res_reg;

endmodule

// ===== rtl/blocked_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// Blocked matrix multiply
// Loads A and B element by element and computes C = A * B in Q32.32 with
// saturation, emitting C column by column through a chain of MAC cells.
//
//   Channel   Signals                          Direction  Flow
//   request   start, busy, request             in         taken on start & !busy
//   result    result_valid, result             out        one cycle, no stall
//   config    psel penable pwrite paddr ...    in/out     APB, pready always 1
//
// A load request does not raise busy, so the next may follow at once.
// A compute request keeps busy high until the final C element of an n x n
// product is out: the sequencer sends one B element per cycle down the
// cell chain, and each cell finishes its element of a column in the cycle
// after its left neighbor. Results cannot be held off by the receiver.
// Reset clears control state and sets active_size to 8; stores are
// undefined until written.
// ----------------------------------------------------------------------------
module blocked_matrix_multiply
    import bmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    output logic        result_valid,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    state_t           state_reg;
    state_t           state_next;
    logic [3:0]       active_size_reg;
    logic [IDX_W-1:0] nlast_reg;
    logic [IDX_W-1:0] nlast_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] j_reg;
    logic             issue;
    logic             accept;
    logic             load_ok;
    logic [3:0]       n_clamped;
    logic [31:0]      b_mem [MAX_DIM*MAX_DIM];
    logic [31:0]      b_rd_reg;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    chain_ctl_t       issue_ctl;
    chain_ctl_t       issue_ctl_reg;
    logic [31:0]      chain_b   [MAX_DIM+1];
    chain_ctl_t       chain_ctl [MAX_DIM+1];
    cell_out_t        cell_res  [MAX_DIM];
    cell_out_t        out_next;
    logic [MAX_DIM-1:0] a_we;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = {28'd0, active_size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= 4'd8;
        end
        else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_SIZE)
        begin
            active_size_reg <= pwdata[3:0];
        end
    end

    // Request decode and size clamping.
    assign accept  = start && !busy;
    assign load_ok = ({1'b0, request.row_index} < 4'(MAX_DIM))
                     && ({1'b0, request.col_index} < 4'(MAX_DIM));

    always_comb
    begin
        n_clamped = active_size_reg;
        if (active_size_reg == 4'd0)
        begin
            n_clamped = 4'd1;
        end
        else if (active_size_reg > 4'(MAX_DIM))
        begin
            n_clamped = 4'(MAX_DIM);
        end
        nlast_next = IDX_W'(n_clamped - 4'd1);
    end

    // Write enables for the A rows held in the cells.
    always_comb
    begin
        for (int i = 0; i < MAX_DIM; i++)
        begin
            a_we[i] = accept && load_ok && request.func == FUNC_LOAD_A
                      && request.row_index == IDX_W'(i);
        end
    end

    // B store, written by loads and read one element per cycle.
    assign wr_addr = AW'(int'(request.row_index) * MAX_DIM + int'(request.col_index));
    assign rd_addr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (accept && load_ok && request.func == FUNC_LOAD_B)
        begin
            b_mem[wr_addr] <= request.element_value;
        end
        b_rd_reg <= b_mem[rd_addr];
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && request.func == FUNC_COMPUTE)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == nlast_reg && j_reg == nlast_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (result_valid && result.last_element)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy  = 1'b1;
        issue = 1'b0;
        case (state_reg)
            ST_IDLE:  busy  = 1'b0;
            ST_RUN:   issue = 1'b1;
            ST_DRAIN: issue = 1'b0;
            default:  busy  = 1'b0;
        endcase
    end

    always_comb
    begin
        issue_ctl          = '0;
        issue_ctl.valid    = issue;
        issue_ctl.first    = (k_reg == '0);
        issue_ctl.last_k   = (k_reg == nlast_reg);
        issue_ctl.last_col = (j_reg == nlast_reg);
        issue_ctl.col      = j_reg;
        issue_ctl.k        = k_reg;
    end

    // Sequencer state register, inner and column counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nlast_reg     <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            issue_ctl_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_ctl_reg <= issue_ctl;
            if (state_reg == ST_IDLE)
            begin
                nlast_reg <= nlast_next;
                k_reg     <= '0;
                j_reg     <= '0;
            end
            else if (issue)
            begin
                if (k_reg == nlast_reg)
                begin
                    k_reg <= '0;
                    j_reg <= j_reg + 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    // Cell chain.
    assign chain_b[0]   = b_rd_reg;
    assign chain_ctl[0] = issue_ctl_reg;

    for (genvar g = 0; g < MAX_DIM; g++)
    begin : g_cell
        bmm_cell #(
            .MAX_DIM (MAX_DIM),
            .INDEX   (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .a_we    (a_we[g]),
            .a_col   (request.col_index),
            .a_data  (request.element_value),
            .nlast   (nlast_reg),
            .b_in    (chain_b[g]),
            .ctl_in  (chain_ctl[g]),
            .b_out   (chain_b[g+1]),
            .ctl_out (chain_ctl[g+1]),
            .res     (cell_res[g])
        );
    end

    // At most one cell finishes per cycle; gather its element.
    always_comb
    begin
        out_next = '0;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            if (cell_res[i].valid)
            begin
                out_next = out_next | cell_res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= out_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result <= out_next.data;
    end

    // Results only appear during a compute run.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result outside a compute run");

    // The final element ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_element |=> !busy)
        else $error("busy after final element");

    // Nothing enters the chain while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy && $past(!busy) |-> !issue_ctl_reg.valid)
        else $error("chain fed while idle");

    // A compute request starts a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && request.func == FUNC_COMPUTE |=> busy)
        else $error("compute request did not start a run");

endmodule
